// File: hdl/plst_pkg.sv
package plst_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_FIND   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_DELETE,
    CELL_FIND
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [DataW-1:0]   value;
  } cell_ctl_t;

endpackage

// File: hdl/positional_sequential_list.sv
// Dense ordered list of signed 32-bit entries held in a chain of cells, one
// entry per cell. Append writes the cell after the last entry; insert and
// delete shift the chain in the cycle the request is taken. Append and
// insert then wait in the hold state until the output is free. Find marks
// cells equal to the value, delete the cell at the position, and a registered
// halving tree resolves the lowest marked one. One request is in flight at a
// time; a new request is taken while the previous result waits on the output.
module positional_sequential_list import plst_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic [7:0]         found_at,
  output logic [7:0]         count
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > 8) ? CW : 8;
  localparam int LOG = $clog2(CAPACITY);
  localparam int SW  = $clog2(LOG + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_HOLD   = 3'b100
  } state_t;

  state_t         state;
  logic [SW-1:0]  step_cnt;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_next;
  logic [1:0]     req_kind;
  logic [1:0]     req_status;
  logic [1:0]     st_calc;
  logic           accept;
  logic           out_free;
  logic [PW-1:0]  pos_w;
  logic [PW-1:0]  cnt_w;
  logic [CW-1:0]  pidx;
  logic           full;
  logic           empty;
  logic           bad_pos;
  cell_ctl_t      ctl;

  logic [DataW-1:0] cell_data [CAPACITY];
  logic             cell_hit  [CAPACITY];
  logic             t_hit;
  logic [LOG-1:0]   t_idx;
  logic [DataW-1:0] t_data;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign pos_w   = PW'(position);
  assign cnt_w   = PW'(cnt);
  assign pidx    = CW'(pos_w - PW'(1));
  assign full    = (cnt == CW'(CAPACITY));
  assign empty   = (cnt == '0);
  assign bad_pos = (position == 8'd0) || (pos_w > cnt_w);

  always_comb begin
    st_calc   = ST_OK;
    cnt_next  = cnt;
    ctl.value = value;
    ctl.op    = CELL_HOLD;
    case (kind)
      KIND_APPEND: begin
        if (full) st_calc = ST_FULL;
        else begin
          ctl.op   = CELL_APPEND;
          cnt_next = cnt + CW'(1);
        end
      end
      KIND_INSERT: begin
        if (full) st_calc = ST_FULL;
        else if (bad_pos) st_calc = ST_BADPOS;
        else begin
          ctl.op   = CELL_INSERT;
          cnt_next = cnt + CW'(1);
        end
      end
      KIND_DELETE: begin
        if (empty) st_calc = ST_EMPTY;
        else if (bad_pos) st_calc = ST_BADPOS;
        else begin
          ctl.op   = CELL_DELETE;
          cnt_next = cnt - CW'(1);
        end
      end
      default: ctl.op = CELL_FIND;
    endcase
    if (!accept) ctl.op = CELL_HOLD;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left_d;
    logic [DataW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    plst_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .pidx  (pidx),
      .cnt   (cnt),
      .left  (left_d),
      .right (right_d),
      .data  (cell_data[i]),
      .hit   (cell_hit[i])
    );
  end

  plst_first #(.N(CAPACITY)) u_first (
    .clk     (clk),
    .load    (accept),
    .step    (state == S_SEARCH),
    .hit_in  (cell_hit),
    .data_in (cell_data),
    .hit     (t_hit),
    .idx     (t_idx),
    .data    (t_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_HOLD && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt      <= cnt_next;
            step_cnt <= '0;
            if (kind == KIND_DELETE || kind == KIND_FIND) state <= S_SEARCH;
            else state <= S_HOLD;
          end
        end
        S_SEARCH: begin
          step_cnt <= step_cnt + SW'(1);
          if (step_cnt == SW'(LOG - 1)) state <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind   <= kind;
      req_status <= st_calc;
    end
    if (state == S_HOLD && out_free) begin
      status <= req_status;
      count  <= 8'(cnt);
      if (req_kind == KIND_DELETE && req_status == ST_OK) removed_value <= $signed(t_data);
      else removed_value <= '0;
      if (req_kind == KIND_FIND && t_hit) found_at <= 8'({1'b0, t_idx} + (LOG + 1)'(1));
      else found_at <= 8'd0;
    end
  end

endmodule

// File: hdl/plst_cell.sv
module plst_cell import plst_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 8
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CW-1:0]    pidx,
  input  logic [CW-1:0]    cnt,
  input  logic [DataW-1:0] left,
  input  logic [DataW-1:0] right,
  output logic [DataW-1:0] data,
  output logic             hit
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_APPEND: begin
        if (MyIdx == cnt) data <= ctl.value;
      end
      CELL_INSERT: begin
        if (MyIdx == pidx) data <= ctl.value;
        else if (MyIdx > pidx) data <= left;
      end
      CELL_DELETE: begin
        if (MyIdx >= pidx) data <= right;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ctl.op)
      CELL_FIND:   hit = (MyIdx < cnt) && (data == ctl.value);
      CELL_DELETE: hit = (MyIdx == pidx);
      default:     hit = 1'b0;
    endcase
  end

endmodule

// File: hdl/plst_first.sv
module plst_first import plst_pkg::*; #(
  parameter int N = 128
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic             hit_in  [N],
  input  logic [DataW-1:0] data_in [N],
  output logic             hit,
  output logic [$clog2(N)-1:0] idx,
  output logic [DataW-1:0] data
);

  localparam int LOG = $clog2(N);
  localparam int P   = 1 << LOG;

  logic             hv [P];
  logic [LOG-1:0]   hi [P];
  logic [DataW-1:0] hd [P];

  // each step halves the candidates, lower index wins
  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < P; j++) begin
        hi[j] <= LOG'(j);
        if (j < N) begin
          hv[j] <= hit_in[j];
          hd[j] <= data_in[j];
        end else begin
          hv[j] <= 1'b0;
          hd[j] <= '0;
        end
      end
    end else if (step) begin
      for (int j = 0; j < P / 2; j++) begin
        if (hv[2*j]) begin
          hv[j] <= 1'b1;
          hi[j] <= hi[2*j];
          hd[j] <= hd[2*j];
        end else begin
          hv[j] <= hv[2*j+1];
          hi[j] <= hi[2*j+1];
          hd[j] <= hd[2*j+1];
        end
      end
      for (int j = P / 2; j < P; j++) hv[j] <= 1'b0;
    end
  end

  assign hit  = hv[0];
  assign idx  = hi[0];
  assign data = hd[0];

endmodule
